// ----- rtl/cau_pkg.sv -----
package cau_pkg;

   // Fixed-point format and internal widths
   localparam int FRAC_BITS   = 16;
   localparam int QBITS       = 33;                  // quotient bits 32..0
   localparam int DIV_W       = 64 + QBITS + 1;      // divider remainder width
   localparam int SQ_BITS     = 32;                  // square root result bits
   localparam int SQ_W        = SQ_BITS + 4;         // square root remainder width
   localparam int PIPE_STAGES = QBITS + 1;           // setup stage plus one per quotient bit

   // Command codes
   localparam logic [3:0] CMD_ADD  = 4'd0;
   localparam logic [3:0] CMD_SUB  = 4'd1;
   localparam logic [3:0] CMD_MUL  = 4'd2;
   localparam logic [3:0] CMD_DIV  = 4'd3;
   localparam logic [3:0] CMD_SADD = 4'd4;
   localparam logic [3:0] CMD_SSUB = 4'd5;
   localparam logic [3:0] CMD_SMUL = 4'd6;
   localparam logic [3:0] CMD_SDIV = 4'd7;
   localparam logic [3:0] CMD_MAG  = 4'd8;
   localparam logic [3:0] CMD_EQ   = 4'd9;
   localparam logic [3:0] CMD_NE   = 4'd10;

   typedef struct packed {
      logic [3:0]         command;
      logic signed [31:0] a_re;
      logic signed [31:0] a_im;
      logic signed [31:0] b_re;
      logic signed [31:0] b_im;
   } cau_req_type;

   typedef struct packed {
      logic signed [31:0] res_re;
      logic signed [31:0] res_im;
      logic               compare_true;
      logic               overflow;
      logic               divide_by_zero;
   } cau_rsp_type;

   // One slot of the divide / square root pipeline
   typedef struct packed {
      logic               is_div;
      logic               is_sqrt;
      logic               div_zero;
      logic               cmp;
      logic               neg_re;
      logic               neg_im;
      logic [63:0]        mag_re;
      logic [63:0]        mag_im;
      logic [63:0]        den;
      logic [DIV_W-1:0]   rem_re;
      logic [DIV_W-1:0]   rem_im;
      logic [QBITS-1:0]   q_re;
      logic [QBITS-1:0]   q_im;
      logic               big_re;
      logic               big_im;
      logic [SQ_W-1:0]    sq_rem;
      logic [SQ_BITS-1:0] sq_root;
   } cau_pipe_type;

endpackage

// ----- rtl/cau_iter_pipe.sv -----
module cau_iter_pipe (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  cau_pkg::cau_pipe_type in_stage,
   output logic                  out_valid,
   output cau_pkg::cau_pipe_type out_stage
);

   cau_pkg::cau_pipe_type                 stg_ff [cau_pkg::PIPE_STAGES];
   logic [cau_pkg::PIPE_STAGES-1:0]       vld_ff;

   for (genvar g = 0; g < cau_pkg::PIPE_STAGES; g++) begin : g_stage
      cau_pkg::cau_pipe_type cur_w;
      cau_pkg::cau_pipe_type nxt_in;
      logic                  cur_v;

      if (g == 0) begin : g_first
         assign cur_w = in_stage;
         assign cur_v = in_valid;
      end else begin : g_next
         assign cur_w = stg_ff[g-1];
         assign cur_v = vld_ff[g-1];
      end

      if (g == 0) begin : g_setup
         // Scale numerators, flag quotients of 2^33 or more
         always_comb begin
            logic [cau_pkg::DIV_W-1:0] num_re;
            logic [cau_pkg::DIV_W-1:0] num_im;
            logic [cau_pkg::DIV_W-1:0] den_top;
            num_re  = {{(cau_pkg::DIV_W-64){1'b0}}, cur_w.mag_re} << cau_pkg::FRAC_BITS;
            num_im  = {{(cau_pkg::DIV_W-64){1'b0}}, cur_w.mag_im} << cau_pkg::FRAC_BITS;
            den_top = {{(cau_pkg::DIV_W-64){1'b0}}, cur_w.den} << cau_pkg::QBITS;
            nxt_in         = cur_w;
            nxt_in.rem_re  = num_re;
            nxt_in.rem_im  = num_im;
            nxt_in.big_re  = (num_re >= den_top);
            nxt_in.big_im  = (num_im >= den_top);
            nxt_in.q_re    = '0;
            nxt_in.q_im    = '0;
            nxt_in.sq_rem  = '0;
            nxt_in.sq_root = '0;
         end
      end else begin : g_iter
         localparam int K    = cau_pkg::PIPE_STAGES - 1 - g;
         // Root bit position, held in range on the stage that has no root bit
         localparam int SQ_K = (K < cau_pkg::SQ_BITS) ? K : 0;

         // Resolve quotient bit K of both lanes, root bit K when in range
         always_comb begin
            logic [cau_pkg::DIV_W-1:0] den_k;
            logic [cau_pkg::SQ_W-1:0]  rem_sh;
            logic [cau_pkg::SQ_W-1:0]  trial;
            den_k  = {{(cau_pkg::DIV_W-64){1'b0}}, cur_w.den} << K;
            rem_sh = '0;
            trial  = '0;
            nxt_in = cur_w;
            if (cur_w.rem_re >= den_k) begin
               nxt_in.rem_re  = cur_w.rem_re - den_k;
               nxt_in.q_re[K] = 1'b1;
            end
            if (cur_w.rem_im >= den_k) begin
               nxt_in.rem_im  = cur_w.rem_im - den_k;
               nxt_in.q_im[K] = 1'b1;
            end
            if (K < cau_pkg::SQ_BITS) begin
               rem_sh = {cur_w.sq_rem[cau_pkg::SQ_W-3:0], cur_w.mag_re[2*SQ_K+1 -: 2]};
               trial  = {2'b00, cur_w.sq_root, 2'b01};
               if (rem_sh >= trial) begin
                  nxt_in.sq_rem  = rem_sh - trial;
                  nxt_in.sq_root = {cur_w.sq_root[cau_pkg::SQ_BITS-2:0], 1'b1};
               end else begin
                  nxt_in.sq_rem  = rem_sh;
                  nxt_in.sq_root = {cur_w.sq_root[cau_pkg::SQ_BITS-2:0], 1'b0};
               end
            end
         end
      end

      // Advance one slot per cycle
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else begin
            vld_ff[g] <= cur_v;
         end
         stg_ff[g] <= nxt_in;
      end
   end

   assign out_valid = vld_ff[cau_pkg::PIPE_STAGES-1];
   assign out_stage = stg_ff[cau_pkg::PIPE_STAGES-1];

endmodule

// ----- rtl/complex_arithmetic_unit.sv -----
// Complex ALU, signed fixed point. A command is taken in every clock cycle in
// which start is high; busy is always low. Each command gives one result on
// rsp_data, marked by rsp_valid for one cycle, in order. A command passes a
// multiplier stage, a sum stage, the divide / square root pipeline, which
// resolves one quotient bit per stage (33 bits plus a setup stage), and the
// saturation register. The receiver cannot stall the result stream, so results
// must be taken as shown.
module complex_arithmetic_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  cau_pkg::cau_req_type req_data,
   output logic                 busy,
   output logic                 rsp_valid,
   output cau_pkg::cau_rsp_type rsp_data
);

   // Stage 1: operands and products
   logic               v1_ff;
   logic [3:0]         cmd1_ff;
   logic signed [31:0] ar1_ff, ai1_ff, br1_ff, bi1_ff;
   logic signed [63:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_bb_ff, p_qq_ff;

   logic signed [31:0] ar_w, ai_w, br_w, bi_w, mx_re_w, mx_im_w;

   // Stage 2 and pipe
   logic                  v2_ff;
   cau_pkg::cau_pipe_type pin_ff;
   cau_pkg::cau_pipe_type pin_in;
   logic                  pout_v;
   cau_pkg::cau_pipe_type pout;

   // Output
   logic                 rsp_valid_ff;
   cau_pkg::cau_rsp_type rsp_ff;
   cau_pkg::cau_rsp_type rsp_in;

   assign busy = 1'b0;

   assign ar_w = req_data.a_re;
   assign ai_w = req_data.a_im;
   assign br_w = req_data.b_re;
   assign bi_w = req_data.b_im;

   // Magnitude squares A with itself
   assign mx_re_w = (req_data.command == cau_pkg::CMD_MAG) ? ar_w : br_w;
   assign mx_im_w = (req_data.command == cau_pkg::CMD_MAG) ? ai_w : bi_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start;
      end
      cmd1_ff <= req_data.command;
      ar1_ff  <= ar_w;
      ai1_ff  <= ai_w;
      br1_ff  <= br_w;
      bi1_ff  <= bi_w;
      p_rr_ff <= ar_w * mx_re_w;
      p_ii_ff <= ai_w * mx_im_w;
      p_ri_ff <= ar_w * bi_w;
      p_ir_ff <= ai_w * br_w;
      p_bb_ff <= br_w * br_w;
      p_qq_ff <= bi_w * bi_w;
   end

   // Stage 2: exact sums as sign and magnitude
   always_comb begin
      logic signed [64:0] ar_x, ai_x, br_x, bi_x;
      logic signed [64:0] s_re, s_im, n_re, n_im;
      logic [31:0]        br_abs;
      logic               shift;
      ar_x   = {{33{ar1_ff[31]}}, ar1_ff};
      ai_x   = {{33{ai1_ff[31]}}, ai1_ff};
      br_x   = {{33{br1_ff[31]}}, br1_ff};
      bi_x   = {{33{bi1_ff[31]}}, bi1_ff};
      br_abs = br1_ff[31] ? 32'(32'd0 - br1_ff) : br1_ff;
      s_re   = '0;
      s_im   = '0;
      shift  = 1'b0;
      pin_in = '0;
      case (cmd1_ff)
         cau_pkg::CMD_ADD: begin
            s_re = ar_x + br_x;
            s_im = ai_x + bi_x;
         end
         cau_pkg::CMD_SUB: begin
            s_re = ar_x - br_x;
            s_im = ai_x - bi_x;
         end
         cau_pkg::CMD_MUL: begin
            s_re  = {p_rr_ff[63], p_rr_ff} - {p_ii_ff[63], p_ii_ff};
            s_im  = {p_ri_ff[63], p_ri_ff} + {p_ir_ff[63], p_ir_ff};
            shift = 1'b1;
         end
         cau_pkg::CMD_DIV: begin
            s_re            = {p_rr_ff[63], p_rr_ff} + {p_ii_ff[63], p_ii_ff};
            s_im            = {p_ir_ff[63], p_ir_ff} - {p_ri_ff[63], p_ri_ff};
            pin_in.den      = p_bb_ff + p_qq_ff;
            pin_in.is_div   = 1'b1;
            pin_in.div_zero = (br1_ff == 32'sd0) && (bi1_ff == 32'sd0);
         end
         cau_pkg::CMD_SADD: begin
            s_re = ar_x + br_x;
            s_im = ai_x;
         end
         cau_pkg::CMD_SSUB: begin
            s_re = ar_x - br_x;
            s_im = ai_x;
         end
         cau_pkg::CMD_SMUL: begin
            s_re  = {p_rr_ff[63], p_rr_ff};
            s_im  = {p_ir_ff[63], p_ir_ff};
            shift = 1'b1;
         end
         cau_pkg::CMD_SDIV: begin
            s_re            = ar_x;
            s_im            = ai_x;
            pin_in.den      = {32'd0, br_abs};
            pin_in.is_div   = 1'b1;
            pin_in.div_zero = (br1_ff == 32'sd0);
         end
         cau_pkg::CMD_MAG: begin
            s_re           = {p_rr_ff[63], p_rr_ff} + {p_ii_ff[63], p_ii_ff};
            pin_in.is_sqrt = 1'b1;
         end
         cau_pkg::CMD_EQ: begin
            pin_in.cmp = (ar1_ff == br1_ff) && (ai1_ff == bi1_ff);
         end
         cau_pkg::CMD_NE: begin
            pin_in.cmp = !((ar1_ff == br1_ff) && (ai1_ff == bi1_ff));
         end
         default: begin
         end
      endcase
      n_re          = -s_re;
      n_im          = -s_im;
      pin_in.neg_re = s_re[64];
      pin_in.neg_im = s_im[64];
      pin_in.mag_re = s_re[64] ? n_re[63:0] : s_re[63:0];
      pin_in.mag_im = s_im[64] ? n_im[63:0] : s_im[63:0];
      if (shift) begin
         pin_in.mag_re = pin_in.mag_re >> cau_pkg::FRAC_BITS;
         pin_in.mag_im = pin_in.mag_im >> cau_pkg::FRAC_BITS;
      end
      // Scalar divide takes its sign from the scalar too
      if (cmd1_ff == cau_pkg::CMD_SDIV) begin
         pin_in.neg_re = ar1_ff[31] ^ br1_ff[31];
         pin_in.neg_im = ai1_ff[31] ^ br1_ff[31];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      pin_ff <= pin_in;
   end

   cau_iter_pipe u_iter (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v2_ff),
      .in_stage  (pin_ff),
      .out_valid (pout_v),
      .out_stage (pout)
   );

   // Saturate a sign and magnitude to 32-bit two's complement; top bit flags overflow
   function automatic logic [32:0] sat32(input logic neg, input logic [63:0] mag);
      logic [63:0] n;
      n = 64'd0 - mag;
      if (neg) begin
         if (mag > 64'h0000_0000_8000_0000) begin
            return {1'b1, 32'h8000_0000};
         end
         return {1'b0, n[31:0]};
      end
      if (mag > 64'h0000_0000_7FFF_FFFF) begin
         return {1'b1, 32'h7FFF_FFFF};
      end
      return {1'b0, mag[31:0]};
   endfunction

   // Select final magnitudes, saturate, drop results of a zero divisor
   always_comb begin
      logic [63:0] m_re, m_im;
      logic [32:0] s_re, s_im;
      m_re = pout.mag_re;
      m_im = pout.mag_im;
      if (pout.is_sqrt) begin
         m_re = {32'd0, pout.sq_root};
      end
      if (pout.is_div) begin
         m_re = pout.big_re ? 64'hFFFF_FFFF_FFFF_FFFF : {{(64-cau_pkg::QBITS){1'b0}}, pout.q_re};
         m_im = pout.big_im ? 64'hFFFF_FFFF_FFFF_FFFF : {{(64-cau_pkg::QBITS){1'b0}}, pout.q_im};
      end
      s_re = sat32(pout.neg_re, m_re);
      s_im = sat32(pout.neg_im, m_im);
      rsp_in.res_re         = s_re[31:0];
      rsp_in.res_im         = s_im[31:0];
      rsp_in.compare_true   = pout.cmp;
      rsp_in.overflow       = s_re[32] | s_im[32];
      rsp_in.divide_by_zero = pout.div_zero;
      if (pout.div_zero) begin
         rsp_in.res_re   = '0;
         rsp_in.res_im   = '0;
         rsp_in.overflow = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= pout_v;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
